FILE: rtl/lge_pkg.sv
// Shared constants, types and codes for the life generation engine.
package lge_pkg;

    localparam int GRID_MAX = 64;
    localparam int ROW_W    = $clog2(GRID_MAX);
    localparam int K_W      = $clog2(GRID_MAX + 1);
    localparam int SIZE_W   = 7;
    localparam int N_W      = (K_W > SIZE_W) ? K_W : SIZE_W;
    localparam int POS_W    = 6;
    localparam int CNT_W    = 13;
    localparam int CHUNK    = 8;
    localparam int CHUNKS   = (GRID_MAX + CHUNK - 1) / CHUNK;
    localparam int VEC_W    = CHUNKS * CHUNK;
    localparam int CHK_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int PC_W     = $clog2(CHUNK + 1);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

    localparam logic [3:0] NB_KEEP = 4'd2;
    localparam logic [3:0] NB_BORN = 4'd3;

    typedef logic [GRID_MAX-1:0] t_row;
    typedef logic [VEC_W-1:0]    t_vec;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_STEP  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CELL_RD,
        S_STEP_RD,
        S_STEP_SHIFT,
        S_STEP_CALC,
        S_STEP_CNT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] waddr;
        t_row             wdata;
        t_row             wmask;
    } t_ram_wr;

endpackage

FILE: rtl/lge_cell_ram.sv
// Row-wide cell buffer: bit-masked write port, one registered read port.
module lge_cell_ram (
    input  logic                      i_clk,
    input  lge_pkg::t_ram_wr          i_wr,
    input  logic [lge_pkg::ROW_W-1:0] i_raddr,
    output lge_pkg::t_row             o_rdata
);
    import lge_pkg::*;

    t_row r_mem [GRID_MAX];
    t_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            for (int i = 0; i < GRID_MAX; i++) begin
                if (i_wr.wmask[i]) begin
                    r_mem[i_wr.waddr][i] <= i_wr.wdata[i];
                end
            end
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/life_generation_engine_top.sv
// Life generation engine top level: request sequencer, step datapath, buffers.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  request | in        | i_valid / o_stall   | i_req_type, i_row, i_col, i_cell_in
//  result  | out       | o_valid / i_stall   | o_cell_out, o_live_total, o_died_total,
//          |           |                     | o_born_total
//  config  | in        | i_cfg_we            | i_cfg_wdata (grid_size)
//
// Write and unknown requests go straight to S_DONE; a read passes through S_CELL_RD first.
// A step walks one row per pass: read, window shift, row update, then a count of
// the new, died and born cells one CHUNK-bit slice at a time.
// After reset both buffers are cleared one row a cycle, all GRID_MAX rows, with o_stall high.
// A stalled result sits in the output register; the next request is still taken.
module life_generation_engine_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lge_pkg::SIZE_W-1:0] i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_req_type,
    input  logic [lge_pkg::POS_W-1:0]  i_row,
    input  logic [lge_pkg::POS_W-1:0]  i_col,
    input  logic                       i_cell_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_cell_out,
    output logic [lge_pkg::CNT_W-1:0]  o_live_total,
    output logic [lge_pkg::CNT_W-1:0]  o_died_total,
    output logic [lge_pkg::CNT_W-1:0]  o_born_total
);
    import lge_pkg::*;

    function automatic logic [PC_W-1:0] pop_chunk(input logic [CHUNK-1:0] v);
        logic [PC_W-1:0] s;
        s = '0;
        for (int i = 0; i < CHUNK; i++) begin
            s = s + PC_W'(v[i]);
        end
        return s;
    endfunction

    t_state            r_state, n_state;
    logic [SIZE_W-1:0] r_size;
    logic              r_cur;
    logic [ROW_W-1:0]  r_clr;
    logic [K_W-1:0]    r_k;
    logic [CHK_W-1:0]  r_chunk;
    t_row              r_top, r_mid, r_bot;
    t_vec              r_new_v, r_died_v, r_born_v;
    logic [CNT_W-1:0]  r_acc_live, r_acc_died, r_acc_born;
    logic              r_acc_cell;
    logic [ROW_W-1:0]  r_col;
    logic              r_hit;
    logic              r_out_valid;
    logic              r_out_cell;
    logic [CNT_W-1:0]  r_out_live, r_out_died, r_out_born;

    t_ram_wr           wr_a, wr_b;
    logic [ROW_W-1:0]  raddr;
    t_row              rdata_a, rdata_b, rd_row;
    t_row              col_mask, new_row;
    logic [N_W-1:0]    eff_n;
    logic              in_acc, in_hit, out_free;
    logic              k_in, row_ok, k_last, chunk_last;
    logic [GRID_MAX+1:0] p_top, p_mid, p_bot;
    logic [3:0]        nb;

    lge_cell_ram u_ram_a (
        .i_clk   (i_clk),
        .i_wr    (wr_a),
        .i_raddr (raddr),
        .o_rdata (rdata_a)
    );

    lge_cell_ram u_ram_b (
        .i_clk   (i_clk),
        .i_wr    (wr_b),
        .i_raddr (raddr),
        .o_rdata (rdata_b)
    );

    assign eff_n      = (N_W'(r_size) > N_W'(GRID_MAX)) ? N_W'(GRID_MAX) : N_W'(r_size);
    assign in_acc     = i_valid && !o_stall;
    assign in_hit     = (N_W'(i_row) < eff_n) && (N_W'(i_col) < eff_n);
    assign out_free   = !r_out_valid || !i_stall;
    assign rd_row     = r_cur ? rdata_b : rdata_a;
    assign k_in       = N_W'(r_k) < eff_n;
    assign row_ok     = N_W'(r_k) <= eff_n;
    assign k_last     = r_k == K_W'(GRID_MAX);
    assign chunk_last = r_chunk == CHK_W'(CHUNKS - 1);

    always_comb begin
        for (int j = 0; j < GRID_MAX; j++) begin
            col_mask[j] = N_W'(j) < eff_n;
        end
    end

    // next row from the three-row window; outside cells are already zero
    always_comb begin
        p_top = {1'b0, r_top, 1'b0};
        p_mid = {1'b0, r_mid, 1'b0};
        p_bot = {1'b0, r_bot, 1'b0};
        nb    = '0;
        for (int j = 0; j < GRID_MAX; j++) begin
            nb = 4'(p_top[j]) + 4'(p_top[j+1]) + 4'(p_top[j+2])
               + 4'(p_mid[j]) + 4'(p_mid[j+2])
               + 4'(p_bot[j]) + 4'(p_bot[j+1]) + 4'(p_bot[j+2]);
            if (nb == NB_KEEP) begin
                new_row[j] = r_mid[j];
            end else begin
                new_row[j] = (nb == NB_BORN);
            end
        end
        new_row = new_row & col_mask;
        if (!row_ok) begin
            new_row = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == ROW_W'(GRID_MAX - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_req_type)
                        REQ_READ: n_state = S_CELL_RD;
                        REQ_STEP: n_state = S_STEP_RD;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_CELL_RD:    n_state = S_DONE;
            S_STEP_RD:    n_state = S_STEP_SHIFT;
            S_STEP_SHIFT: n_state = (r_k == '0) ? S_STEP_RD : S_STEP_CALC;
            S_STEP_CALC:  n_state = S_STEP_CNT;
            S_STEP_CNT: begin
                if (chunk_last) begin
                    n_state = k_last ? S_DONE : S_STEP_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        wr_a    = '0;
        wr_b    = '0;
        raddr   = ROW_W'(i_row);
        o_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_CLEAR: begin
                wr_a.we    = 1'b1;
                wr_a.waddr = r_clr;
                wr_a.wmask = '1;
                wr_b       = wr_a;
            end
            S_IDLE: begin
                if (in_acc && (i_req_type == REQ_WRITE) && in_hit) begin
                    wr_a.we    = !r_cur;
                    wr_a.waddr = ROW_W'(i_row);
                    wr_a.wdata = {GRID_MAX{i_cell_in}};
                    wr_a.wmask = t_row'(1) << ROW_W'(i_col);
                    wr_b       = wr_a;
                    wr_b.we    = r_cur;
                end
            end
            S_STEP_RD: begin
                raddr = r_k[ROW_W-1:0];
            end
            S_STEP_CALC: begin
                wr_a.we    = r_cur;
                wr_a.waddr = ROW_W'(r_k - K_W'(1));
                wr_a.wdata = new_row;
                wr_a.wmask = '1;
                wr_b       = wr_a;
                wr_b.we    = !r_cur;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_size      <= SIZE_RESET;
            r_cur       <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: r_clr <= r_clr + ROW_W'(1);
                S_IDLE: begin
                    if (in_acc) begin
                        r_acc_live <= '0;
                        r_acc_died <= '0;
                        r_acc_born <= '0;
                        r_acc_cell <= 1'b0;
                        r_col      <= ROW_W'(i_col);
                        r_hit      <= in_hit;
                        r_k        <= '0;
                        r_top      <= '0;
                        r_mid      <= '0;
                        r_bot      <= '0;
                    end
                end
                S_CELL_RD: r_acc_cell <= r_hit & rd_row[r_col];
                S_STEP_SHIFT: begin
                    r_top <= r_mid;
                    r_mid <= r_bot;
                    r_bot <= k_in ? (rd_row & col_mask) : '0;
                    if (r_k == '0) begin
                        r_k <= K_W'(1);
                    end
                end
                S_STEP_CALC: begin
                    r_new_v  <= t_vec'(new_row);
                    r_died_v <= t_vec'(r_mid & ~new_row);
                    r_born_v <= t_vec'(~r_mid & new_row);
                    r_chunk  <= '0;
                end
                S_STEP_CNT: begin
                    r_acc_live <= r_acc_live + CNT_W'(pop_chunk(r_new_v[CHUNK-1:0]));
                    r_acc_died <= r_acc_died + CNT_W'(pop_chunk(r_died_v[CHUNK-1:0]));
                    r_acc_born <= r_acc_born + CNT_W'(pop_chunk(r_born_v[CHUNK-1:0]));
                    r_new_v    <= r_new_v >> CHUNK;
                    r_died_v   <= r_died_v >> CHUNK;
                    r_born_v   <= r_born_v >> CHUNK;
                    r_chunk    <= r_chunk + CHK_W'(1);
                    if (chunk_last) begin
                        if (k_last) begin
                            r_cur <= !r_cur;
                        end else begin
                            r_k <= r_k + K_W'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_cell  <= r_acc_cell;
                        r_out_live  <= r_acc_live;
                        r_out_died  <= r_acc_died;
                        r_out_born  <= r_acc_born;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cell_out   = r_out_cell;
    assign o_live_total = r_out_live;
    assign o_died_total = r_out_died;
    assign o_born_total = r_out_born;

endmodule

FILE: rtl/lge_checker.sv
// Port-level checks for the life generation engine, bound to the top level.
module lge_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_stall,
    input logic                      o_valid,
    input logic                      o_stall,
    input logic                      o_cell_out,
    input logic [lge_pkg::CNT_W-1:0] o_live_total,
    input logic [lge_pkg::CNT_W-1:0] o_died_total,
    input logic [lge_pkg::CNT_W-1:0] o_born_total
);
    import lge_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cell_out) && $stable(o_live_total)
                               && $stable(o_died_total) && $stable(o_born_total))
        else $error("stalled result transaction changed");

    a_read_no_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cell_out |-> o_live_total == '0 && o_died_total == '0
                                  && o_born_total == '0)
        else $error("read result carries generation counts");

    a_born_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_born_total <= o_live_total)
        else $error("more cells born than live");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("block not quiet after reset");

endmodule

bind life_generation_engine_top lge_checker u_lge_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_stall      (i_stall),
    .o_valid      (o_valid),
    .o_stall      (o_stall),
    .o_cell_out   (o_cell_out),
    .o_live_total (o_live_total),
    .o_died_total (o_died_total),
    .o_born_total (o_born_total)
);

FILE: bench/tb.sv
// Testbench for life_generation_engine_top: random and directed requests, predictor check.
`timescale 1ns / 1ps

module tb;
    import lge_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             cell_in;
    } t_life_req;

    typedef struct packed {
        logic             cell_out;
        logic [CNT_W-1:0] live;
        logic [CNT_W-1:0] died;
        logic [CNT_W-1:0] born;
    } t_life_res;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [SIZE_W-1:0] i_cfg_wdata = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [1:0]        i_req_type = '0;
    logic [POS_W-1:0]  i_row = '0;
    logic [POS_W-1:0]  i_col = '0;
    logic              i_cell_in = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic              o_cell_out;
    logic [CNT_W-1:0]  o_live_total;
    logic [CNT_W-1:0]  o_died_total;
    logic [CNT_W-1:0]  o_born_total;

    life_generation_engine_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_cell_in    (i_cell_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cell_out   (o_cell_out),
        .o_live_total (o_live_total),
        .o_died_total (o_died_total),
        .o_born_total (o_born_total)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    bit [GRID_MAX-1:0] board [2][GRID_MAX];
    int                front = 0;
    int                grid_size = 64;

    t_life_req req_q [$];
    t_life_res want_q [$];
    t_life_req next_req;
    t_life_res got_want;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        err_count = 0;

    task automatic report_mismatch(string what, int want_v, int got_v);
        $display("ERROR @%0t: %s expected %0d got %0d", $realtime, what, want_v, got_v);
        err_count++;
    endtask

    function automatic int alive_at(int b, int r, int c, int n);
        if (r < 0 || c < 0 || r >= n || c >= n) return 0;
        return board[b][r][c];
    endfunction

    function automatic t_life_res life_apply(t_life_req q);
        t_life_res res;
        int n, r, c, dr, dc, nb, old, nv, back;
        res = '0;
        n = (grid_size > GRID_MAX) ? GRID_MAX : grid_size;
        case (q.kind)
            REQ_WRITE: begin
                if (q.row < n && q.col < n) board[front][q.row][q.col] = q.cell_in;
            end
            REQ_READ: begin
                res.cell_out = (alive_at(front, q.row, q.col, n) != 0);
            end
            REQ_STEP: begin
                back = front ^ 1;
                for (r = 0; r < GRID_MAX; r++) begin
                    for (c = 0; c < GRID_MAX; c++) begin
                        if (r >= n || c >= n) begin
                            board[back][r][c] = 1'b0;
                        end else begin
                            old = alive_at(front, r, c, n);
                            nb = 0;
                            for (dr = -1; dr <= 1; dr++)
                                for (dc = -1; dc <= 1; dc++)
                                    if (dr != 0 || dc != 0)
                                        nb += alive_at(front, r + dr, c + dc, n);
                            if (nb == NB_KEEP) begin
                                nv = old;
                            end else if (nb == NB_BORN) begin
                                if (old == 0) res.born++;
                                nv = 1;
                            end else begin
                                if (old != 0) res.died++;
                                nv = 0;
                            end
                            board[back][r][c] = nv[0];
                            res.live += nv[CNT_W-1:0];
                        end
                    end
                end
                front = back;
            end
            default: ;
        endcase
        return res;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && o_stall) begin
            // hold the stalled transaction
        end else begin
            if (i_valid) want_q.push_back(life_apply({i_req_type, i_row, i_col, i_cell_in}));
            if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = req_q.pop_front();
                i_valid <= 1'b1;
                i_req_type <= next_req.kind;
                i_row <= next_req.row;
                i_col <= next_req.col;
                i_cell_in <= next_req.cell_in;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (want_q.size() == 0) begin
                report_mismatch("result with no request pending", -1, o_live_total);
            end else begin
                got_want = want_q.pop_front();
                if (o_cell_out !== got_want.cell_out)
                    report_mismatch("cell_out", got_want.cell_out, o_cell_out);
                if (o_live_total !== got_want.live)
                    report_mismatch("live_total", got_want.live, o_live_total);
                if (o_died_total !== got_want.died)
                    report_mismatch("died_total", got_want.died, o_died_total);
                if (o_born_total !== got_want.born)
                    report_mismatch("born_total", got_want.born, o_born_total);
            end
        end
    end

    task automatic add_req(logic [1:0] kind, int row, int col, logic cell_in);
        req_q.push_back({kind, row[POS_W-1:0], col[POS_W-1:0], cell_in});
    endtask

    task automatic wait_quiet();
        do @(posedge i_clk); while (req_q.size() != 0 || want_q.size() != 0 || i_valid);
    endtask

    task automatic write_size(int value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value[SIZE_W-1:0];
        grid_size = value & 'h7f;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick_pos(int n);
        if (n > 0 && $urandom_range(3) != 0) return $urandom_range(n - 1, 0);
        return $urandom_range(GRID_MAX - 1, 0);
    endfunction

    task automatic run_phase(int size, int idle_pct, int hold_pct, int count);
        int n, i, pick;
        wait_quiet();
        write_size(size);
        send_idle_pct = idle_pct;
        stall_pct = hold_pct;
        n = (grid_size > GRID_MAX) ? GRID_MAX : grid_size;
        for (i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 45)
                add_req(REQ_WRITE, pick_pos(n), pick_pos(n), 1'($urandom_range(1)));
            else if (pick < 75)
                add_req(REQ_READ, pick_pos(n), pick_pos(n), 1'($urandom_range(1)));
            else if (pick < 93)
                add_req(REQ_STEP, $urandom_range(63), $urandom_range(63),
                        1'($urandom_range(1)));
            else
                add_req(REQ_UNKNOWN, $urandom_range(63), $urandom_range(63),
                        1'($urandom_range(1)));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (o_stall);

        write_size(64);
        add_req(REQ_WRITE, 0, 0, 1'b1);
        add_req(REQ_WRITE, 63, 63, 1'b1);
        add_req(REQ_WRITE, 0, 63, 1'b1);
        add_req(REQ_WRITE, 63, 0, 1'b1);
        add_req(REQ_READ, 0, 0, 1'b0);
        add_req(REQ_READ, 63, 63, 1'b1);
        add_req(REQ_READ, 31, 17, 1'b0);
        add_req(REQ_WRITE, 10, 9, 1'b1);
        add_req(REQ_WRITE, 10, 10, 1'b1);
        add_req(REQ_WRITE, 10, 11, 1'b1);
        add_req(REQ_STEP, 0, 0, 1'b0);
        add_req(REQ_READ, 9, 10, 1'b0);
        add_req(REQ_READ, 11, 10, 1'b0);
        add_req(REQ_READ, 0, 0, 1'b0);
        add_req(REQ_STEP, 63, 63, 1'b1);
        add_req(REQ_READ, 10, 9, 1'b0);
        add_req(REQ_WRITE, 10, 9, 1'b0);
        add_req(REQ_READ, 10, 9, 1'b1);
        add_req(REQ_UNKNOWN, 63, 63, 1'b1);
        add_req(REQ_WRITE, 42, 42, 1'b1);
        add_req(REQ_WRITE, 42, 43, 1'b1);
        add_req(REQ_WRITE, 43, 42, 1'b1);
        add_req(REQ_STEP, 0, 0, 1'b0);
        add_req(REQ_READ, 43, 43, 1'b0);

        run_phase(8,   0,  0,  20);
        run_phase(1,   46, 0,  15);
        run_phase(0,   0,  46, 10);
        run_phase(127, 22, 22, 15);
        run_phase(5,   46, 0,  15);
        run_phase(64,  0,  46, 20);
        run_phase(3,   22, 22, 21);

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (want_q.size() != 0) report_mismatch("results never returned", 0, want_q.size());
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
